@@ rtl/ghst_pkg.sv @@
// ----------------------------------------------------------------------------
// ghst_pkg
// Shared widths, operation codes and status codes of the slot table.
// ----------------------------------------------------------------------------
package ghst_pkg;

  localparam int unsigned SLOTS    = 256;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = SLOT_W + 1;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

endpackage

@@ rtl/ghst_req_if.sv @@
// ----------------------------------------------------------------------------
// ghst_req_if
// Request channel of the slot table: operation and handle fields.
// ----------------------------------------------------------------------------
interface ghst_req_if import ghst_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   handle_index;
  logic [GEN_W-1:0]    handle_generation;
  logic [ID_W-1:0]     requested_id;

  modport source (
    output valid, kind, handle_index, handle_generation, requested_id,
    input  ready
  );

  modport sink (
    input  valid, kind, handle_index, handle_generation, requested_id,
    output ready
  );

endinterface

@@ rtl/ghst_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ghst_rsp_if
// Response channel of the slot table: status, slot and assigned ID.
// ----------------------------------------------------------------------------
interface ghst_rsp_if import ghst_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [GEN_W-1:0]    slot_generation;
  logic [ID_W-1:0]     assigned_id;

  modport source (
    output valid, status, slot_index, slot_generation, assigned_id,
    input  ready
  );

  modport sink (
    input  valid, status, slot_index, slot_generation, assigned_id,
    output ready
  );

endinterface

@@ rtl/generational_handle_slot_table_core.sv @@
// ----------------------------------------------------------------------------
// generational_handle_slot_table_core
// Slot table that hands out generational handles and validates them.
// ----------------------------------------------------------------------------
// Each request gives exactly one response. Allocate pops the most recently
// freed slot or takes the next never-used one and returns its index,
// generation and ID; lookup and free check a handle against the slot's
// occupancy and generation; clear empties the table and restarts IDs at 1.
// A request goes from its transfer to its response in steps: the free
// stack memory is read in the first, the generation memory is read in the
// second at the slot chosen from that, and the third decides, writes back and
// loads the response register. The next request is taken in the cycle after
// that, so a request is only taken once the last one is done; a response
// left waiting holds only the third step. The occupancy bit of each slot is
// kept beside its generation in the same memory; clear only resets the
// counts, since a slot is only checked below the used count and is written
// again when it is next taken as a new slot.
// ----------------------------------------------------------------------------
module generational_handle_slot_table_core import ghst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ghst_req_if.sink    req_i,
  ghst_rsp_if.source  rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_GEN  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [KIND_W-1:0] kind_q;
  logic [SLOT_W-1:0] idx_q;
  logic [GEN_W-1:0]  gen_q;
  logic [ID_W-1:0]   reqid_q;

  logic [CNT_W-1:0]  free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]  used_cnt_q, used_cnt_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;

  logic [GEN_W:0]    gen_mem [SLOTS];
  logic [SLOT_W-1:0] stk_mem [SLOTS];
  logic [SLOT_W-1:0] stk_rd_q;
  logic [GEN_W-1:0]  gen_rd_q;
  logic              occ_rd_q;

  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [SLOT_W-1:0]   rsp_idx_q, rsp_idx_d;
  logic [GEN_W-1:0]    rsp_gen_q, rsp_gen_d;
  logic [ID_W-1:0]     rsp_id_q, rsp_id_d;

  logic              accept;
  logic              fire;
  logic              from_stack;
  logic              is_new;
  logic [SLOT_W-1:0] stk_raddr;
  logic [SLOT_W-1:0] gen_raddr;
  logic [SLOT_W-1:0] alloc_slot;
  logic [GEN_W-1:0]  alloc_gen;
  logic [GEN_W-1:0]  free_gen;
  logic              handle_ok;
  logic              gen_we;
  logic [SLOT_W-1:0] gen_waddr;
  logic [GEN_W-1:0]  gen_wdata;
  logic              gen_wocc;
  logic              stk_we;

  function automatic logic [ID_W-1:0] bump_id(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] n;
    n = v + ID_W'(1);
    return (n == '0) ? ID_W'(1) : n;
  endfunction

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign fire        = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  assign from_stack = (free_cnt_q != '0);
  assign is_new     = !from_stack && (used_cnt_q < CNT_W'(SLOTS));
  assign stk_raddr  = free_cnt_q[SLOT_W-1:0] - SLOT_W'(1);
  assign gen_raddr  = (kind_e'(kind_q) == KIND_ALLOC && from_stack) ? stk_rd_q : idx_q;

  // decision and write-back of the request in flight
  always_comb begin
    alloc_slot = from_stack ? stk_rd_q : used_cnt_q[SLOT_W-1:0];
    alloc_gen  = (is_new || gen_rd_q == '0) ? GEN_W'(1) : gen_rd_q;
    free_gen   = gen_rd_q + GEN_W'(1);
    if (free_gen == '0) begin
      free_gen = GEN_W'(1);
    end
    handle_ok = (gen_q != '0) && (CNT_W'(idx_q) < used_cnt_q) && occ_rd_q
                && (gen_rd_q == gen_q);

    rsp_status_d = STATUS_OK;
    rsp_idx_d    = '0;
    rsp_gen_d    = '0;
    rsp_id_d     = '0;
    gen_we       = 1'b0;
    gen_waddr    = idx_q;
    gen_wdata    = free_gen;
    gen_wocc     = 1'b0;
    stk_we       = 1'b0;
    free_cnt_d   = free_cnt_q;
    used_cnt_d   = used_cnt_q;
    next_id_d    = next_id_q;

    unique case (kind_e'(kind_q))
      KIND_ALLOC: begin
        if (from_stack || is_new) begin
          gen_we    = 1'b1;
          gen_waddr = alloc_slot;
          gen_wdata = alloc_gen;
          gen_wocc  = 1'b1;
          if (from_stack) begin
            free_cnt_d = free_cnt_q - CNT_W'(1);
          end else begin
            used_cnt_d = used_cnt_q + CNT_W'(1);
          end
          if (reqid_q == '0) begin
            rsp_id_d  = next_id_q;
            next_id_d = bump_id(next_id_q);
          end else begin
            rsp_id_d = reqid_q;
            if (reqid_q >= next_id_q) begin
              next_id_d = bump_id(reqid_q);
            end
          end
          rsp_idx_d = alloc_slot;
          rsp_gen_d = alloc_gen;
        end else begin
          rsp_status_d = STATUS_FULL;
        end
      end
      KIND_LOOKUP: begin
        if (handle_ok) begin
          rsp_idx_d = idx_q;
          rsp_gen_d = gen_rd_q;
        end else begin
          rsp_status_d = STATUS_BAD;
        end
      end
      KIND_FREE: begin
        if (handle_ok) begin
          gen_we = 1'b1;
          if (free_cnt_q < CNT_W'(SLOTS)) begin
            stk_we     = 1'b1;
            free_cnt_d = free_cnt_q + CNT_W'(1);
          end
          rsp_idx_d = idx_q;
          rsp_gen_d = free_gen;
        end else begin
          rsp_status_d = STATUS_BAD;
        end
      end
      KIND_CLEAR: begin
        free_cnt_d = '0;
        used_cnt_d = '0;
        next_id_d  = ID_W'(1);
      end
      default: begin
        rsp_status_d = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_GEN;
        end
      end
      S_GEN: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_cnt_q  <= '0;
      used_cnt_q  <= '0;
      next_id_q   <= ID_W'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        free_cnt_q  <= free_cnt_d;
        used_cnt_q  <= used_cnt_d;
        next_id_q   <= next_id_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= req_i.kind;
      idx_q   <= req_i.handle_index;
      gen_q   <= req_i.handle_generation;
      reqid_q <= req_i.requested_id;
    end
    if (fire) begin
      rsp_status_q <= rsp_status_d;
      rsp_idx_q    <= rsp_idx_d;
      rsp_gen_q    <= rsp_gen_d;
      rsp_id_q     <= rsp_id_d;
    end
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (fire && stk_we) begin
      stk_mem[free_cnt_q[SLOT_W-1:0]] <= idx_q;
    end
    if (state_q == S_IDLE) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  // generation and occupancy memory
  always_ff @(posedge clk_i) begin
    if (fire && gen_we) begin
      gen_mem[gen_waddr] <= {gen_wocc, gen_wdata};
    end
    if (state_q == S_GEN) begin
      {occ_rd_q, gen_rd_q} <= gen_mem[gen_raddr];
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.slot_index      = rsp_idx_q;
  assign rsp_o.slot_generation = rsp_gen_q;
  assign rsp_o.assigned_id     = rsp_id_q;

`ifndef SYNTHESIS
  a_free_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= used_cnt_q)
    else $error("free count above used count");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= CNT_W'(SLOTS))
    else $error("used count above slot count");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_GEN ##1 state_q == S_EXEC)
    else $error("request did not walk through the read steps");

  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_EXEC)
    else $error("response raised outside the decide step");
`endif

endmodule
